// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define FFCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define FFCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== rtl/ffcp_pkg.sv =====
`default_nettype none

package ffcp_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int LEN_W       = 16;
    localparam int ADDR_W      = 32;
    localparam int STAT_W      = 2;
    localparam int FREE_W      = 5;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int IN_BITS     = LEN_W + ADDR_W;
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STAT_W + LEN_W + ADDR_W + FREE_W;
    localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_REQ = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0]
    {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;
        logic exec;
    } cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic slot_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_chunk_pool_unit.sv =====
// an accepted request is captured, then executed in S_EXEC once the output register is free
// a new request is not accepted until the previous one has executed: a capture step plus one
//   compare/compact step over the 16-entry table
// a stalled output holds the engine in its execute step until m_tready
// reset clears the entry count, the controller and the output valid; table
//   contents stay undefined until written
`default_nettype none

module first_fit_chunk_pool_unit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [ffcp_pkg::IN_W-1:0]   s_tdata,  // length, base_address
    input  wire logic [0:0]                  s_tuser,  // operation
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [ffcp_pkg::OUT_W-1:0]       m_tdata   // status, granted_length, granted_base, free_count
);
    import ffcp_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic [STAT_W-1:0] out_status;
    logic [LEN_W-1:0]  out_len;
    logic [ADDR_W-1:0] out_base;
    logic [FREE_W-1:0] out_free;

    ffcp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffcp_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser[0]),
        .in_len     (s_tdata[LEN_W-1:0]),
        .in_base    (s_tdata[LEN_W+ADDR_W-1:LEN_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_len    (out_len),
        .out_base   (out_base),
        .out_free   (out_free)
    );

    assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, out_free, out_base, out_len, out_status};

endmodule

`default_nettype wire

// ===== rtl/ffcp_ctrl.sv =====
`default_nettype none

module ffcp_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire ffcp_pkg::sts_t  sts,
    output ffcp_pkg::cmd_t       cmd
);
    import ffcp_pkg::*;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait until the output register can take the result
                if (sts.slot_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ffcp_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"

module ffcp_datapath
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ffcp_pkg::cmd_t                cmd,
    output ffcp_pkg::sts_t                     sts,
    input  wire logic                          in_op,
    input  wire logic [ffcp_pkg::LEN_W-1:0]    in_len,
    input  wire logic [ffcp_pkg::ADDR_W-1:0]   in_base,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ffcp_pkg::STAT_W-1:0]        out_status,
    output logic [ffcp_pkg::LEN_W-1:0]         out_len,
    output logic [ffcp_pkg::ADDR_W-1:0]        out_base,
    output logic [ffcp_pkg::FREE_W-1:0]        out_free
);
    import ffcp_pkg::*;

    // chunk table, contents undefined until written
    logic [LEN_W-1:0]  len_tab_reg  [MAX_ENTRIES];
    logic [ADDR_W-1:0] base_tab_reg [MAX_ENTRIES];
    logic [LEN_W-1:0]  len_tab_next  [MAX_ENTRIES];
    logic [ADDR_W-1:0] base_tab_next [MAX_ENTRIES];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    op_t               op_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] base_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [STAT_W-1:0] out_status_next;
    logic [LEN_W-1:0]  out_len_reg;
    logic [LEN_W-1:0]  out_len_next;
    logic [ADDR_W-1:0] out_base_reg;
    logic [ADDR_W-1:0] out_base_next;
    logic [FREE_W-1:0] out_free_reg;
    logic [FREE_W-1:0] out_free_next;

    logic [MAX_ENTRIES-1:0] hit;
    logic                   found;
    logic [IDX_W-1:0]       hit_idx;
    logic                   full;

    assign full = (count_reg >= CNT_W'(MAX_ENTRIES));

    // parallel compare against every valid entry
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            hit[i] = (CNT_W'(i) < count_reg) && (len_tab_reg[i] >= len_reg);
        end
    end

    // first-hit priority encoder
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            len_tab_next[j]  = len_tab_reg[j];
            base_tab_next[j] = base_tab_reg[j];
        end
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_base_next   = out_base_reg;
        out_free_next   = out_free_reg;

        if (cmd.exec)
        begin
            out_len_next  = '0;
            out_base_next = '0;
            if (op_reg == OP_ADD)
            begin
                if (full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    out_status_next = ST_OK;
                    for (int j = 0; j < MAX_ENTRIES; j++)
                    begin
                        if (count_reg[IDX_W-1:0] == IDX_W'(j))
                        begin
                            len_tab_next[j]  = len_reg;
                            base_tab_next[j] = base_reg;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (found)
            begin
                out_status_next = ST_OK;
                out_len_next    = len_tab_reg[hit_idx];
                out_base_next   = base_tab_reg[hit_idx];
                // entries past the hit move up one place
                for (int j = 0; j < MAX_ENTRIES - 1; j++)
                begin
                    if (IDX_W'(j) >= hit_idx)
                    begin
                        len_tab_next[j]  = len_tab_reg[j+1];
                        base_tab_next[j] = base_tab_reg[j+1];
                    end
                end
                count_next = count_reg - CNT_W'(1);
            end
            else
            begin
                out_status_next = ST_NOFIT;
            end
            out_free_next = FREE_W'(count_next);
        end
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            len_tab_reg[j]  <= len_tab_next[j];
            base_tab_reg[j] <= base_tab_next[j];
        end
        if (cmd.load)
        begin
            op_reg   <= op_t'(in_op);
            len_reg  <= in_len;
            base_reg <= in_base;
        end
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_base_reg   <= out_base_next;
        out_free_reg   <= out_free_next;
    end

    assign sts.slot_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_len       = out_len_reg;
    assign out_base      = out_base_reg;
    assign out_free      = out_free_reg;

    `FFCP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_ENTRIES), "entry count over table size")
    `FFCP_ASSERT(a_exec_slot, clk, rst_n, cmd.exec |-> (!out_valid_reg || out_ready), "result would overwrite a pending output")
    `FFCP_ASSERT_NEXT(a_add_grows, clk, rst_n, cmd.exec && op_reg == OP_ADD && !full, count_reg == $past(count_reg) + CNT_W'(1), "add did not grow the table")
    `FFCP_ASSERT_NEXT(a_grant_shrinks, clk, rst_n, cmd.exec && op_reg == OP_REQ && found, count_reg == $past(count_reg) - CNT_W'(1), "grant did not shrink the table")

endmodule

`default_nettype wire

// ===== dv/first_fit_chunk_pool_unit_tb.sv =====
`timescale 1ns / 100ps

module first_fit_chunk_pool_unit_tb;

    import ffcp_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 12;
    localparam int IDLE_PERCENT  = 7;

    // m_tdata field offsets, lowest bit up
    localparam int GLEN_LSB  = STAT_W;
    localparam int GBASE_LSB = STAT_W + LEN_W;
    localparam int FREE_LSB  = STAT_W + LEN_W + ADDR_W;

    typedef struct packed
    {
        status_t             status;
        logic [LEN_W-1:0]    glen;
        logic [ADDR_W-1:0]   gbase;
        logic [FREE_W-1:0]   free;
    } grant_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic [0:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    // predictor copy of the free-chunk table
    logic [LEN_W-1:0]     pool_len  [MAX_ENTRIES];
    logic [ADDR_W-1:0]    pool_base [MAX_ENTRIES];
    int                   pool_count = 0;

    grant_t               grant_q [$];
    int                   error_count = 0;
    int                   idle_cycles = 0;
    bit                   quiet       = 1'b1;
    bit                   hold_req    = 1'b0;
    bit                   hold_seen   = 1'b0;
    int                   hold_left   = 0;

    first_fit_chunk_pool_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // length, base_address
        .s_tuser  (s_tuser),   // operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status, granted_length, granted_base, free_count
    );

    always #1 clk = ~clk;

    // first-fit append / take on the predictor table
    function automatic grant_t append_or_take(op_t op, logic [LEN_W-1:0] len,
                                              logic [ADDR_W-1:0] base);
        grant_t g;
        bit     found;
        g = '0;
        found = 1'b0;
        if (op == OP_ADD)
        begin
            if (pool_count >= MAX_ENTRIES)
                g.status = ST_FULL;
            else
            begin
                pool_len[pool_count]  = len;
                pool_base[pool_count] = base;
                pool_count++;
                g.status = ST_OK;
            end
        end
        else
        begin
            g.status = ST_NOFIT;
            for (int i = 0; i < pool_count; i++)
            begin
                if (!found && pool_len[i] >= len)
                begin
                    found   = 1'b1;
                    g.status = ST_OK;
                    g.glen  = pool_len[i];
                    g.gbase = pool_base[i];
                    for (int j = i + 1; j < pool_count; j++)
                    begin
                        pool_len[j-1]  = pool_len[j];
                        pool_base[j-1] = pool_base[j];
                    end
                    pool_count--;
                end
            end
        end
        g.free = pool_count[FREE_W-1:0];
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(op_t op, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] base);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {base, len};
        do
            @(posedge clk);
        while (!s_tready);
        grant_q.push_back(append_or_take(op, len, base));
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (grant_q.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            else
            begin
                want = grant_q.pop_front();
                if (m_tdata[STAT_W-1:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[STAT_W-1:0]), 32'(want.status));
                if (m_tdata[GLEN_LSB +: LEN_W] !== want.glen)
                    report_mismatch("granted_length", 32'(m_tdata[GLEN_LSB +: LEN_W]),
                                    32'(want.glen));
                if (m_tdata[GBASE_LSB +: ADDR_W] !== want.gbase)
                    report_mismatch("granted_base", m_tdata[GBASE_LSB +: ADDR_W], want.gbase);
                if (m_tdata[FREE_LSB +: FREE_W] !== want.free)
                    report_mismatch("free_count", 32'(m_tdata[FREE_LSB +: FREE_W]),
                                    32'(want.free));
            end
        end
    end

    // receiver: random idling plus a long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_empty_requests();
        send_item(OP_REQ, '0, '0);
        send_item(OP_REQ, '1, '1);
    endtask

    // fill the table with extreme fields, then one add too many
    task automatic test_table_full();
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            case (i)
                0:       begin len = '0;      base = '0;           end
                1:       begin len = '1;      base = '1;           end
                2:       begin len = 16'h0100; base = 32'hAAAA_AAAA; end
                3:       begin len = 16'h0200; base = 32'h5555_5555; end
                default: begin len = LEN_W'(i * 16'h0100); base = $urandom(); end
            endcase
            send_item(OP_ADD, len, base);
        end
        send_item(OP_ADD, 16'h1234, $urandom());
    endtask

    task automatic test_first_fit();
        send_item(OP_REQ, '0, '1);        // zero length takes the head
        send_item(OP_REQ, '1, '0);        // only the all-ones chunk fits
        send_item(OP_REQ, 16'h8000, '0);  // nothing fits in a non-empty table
        send_item(OP_REQ, 16'h0450, '0);  // first chunk at or above the length
    endtask

    task automatic random_item(int add_pct);
        logic [LEN_W-1:0] len;
        int               pick;
        case ($urandom_range(0, 3))
            0:       len = LEN_W'($urandom_range(0, 15));
            1:       len = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: len = LEN_W'($urandom());
        endcase
        if ($urandom_range(0, 99) < add_pct)
            send_item(OP_ADD, len, $urandom());
        else
        begin
            // aim near stored lengths so hits and near misses both happen
            if (pool_count > 0 && $urandom_range(0, 1) != 0)
            begin
                pick = $urandom_range(0, pool_count - 1);
                len  = pool_len[pick];
                if ($urandom_range(0, 2) == 0)
                    len = len + 1'b1;
                else if ($urandom_range(0, 1) != 0 && len != 0)
                    len = len - 1'b1;
            end
            send_item(OP_REQ, len, $urandom());
        end
    endtask

    task automatic test_random_traffic(int n, bit no_idle);
        int add_pct;
        quiet   = no_idle;
        add_pct = 50;
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
                add_pct = $urandom_range(25, 75);
            random_item(add_pct);
        end
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        quiet    = 1'b1;
        hold_req = ~hold_req;
        for (int k = 0; k < 24; k++)
            random_item(50);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_requests();
        test_table_full();
        test_first_fit();
        test_random_traffic(200, 1'b1);
        test_backpressure();
        test_random_traffic(1000, 1'b0);

        s_tvalid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ffcp_pkg.sv
rtl/ffcp_ctrl.sv
rtl/ffcp_datapath.sv
rtl/first_fit_chunk_pool_unit.sv
dv/first_fit_chunk_pool_unit_tb.sv
